### hw/rtl/irpw_pkg.sv
`timescale 1ns / 1ps

package irpw_pkg;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 2'd2;

	// Register reset values
	localparam logic [7:0] LEADER_MIN_RST    = 8'd9;
	localparam logic [7:0] LEADER_MAX_RST    = 8'd16;
	localparam logic [7:0] ONE_THRESHOLD_RST = 8'd7;

	// Data slots 1..32 map onto bits 0..31
	localparam int unsigned DATA_BITS = 32;

	typedef struct packed {
		logic [7:0] leader_min;
		logic [7:0] leader_max;
		logic [7:0] one_threshold;
	} cfg_t;

	typedef struct packed {
		logic       frame_ready;
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
	} result_t;

	typedef struct packed {
		logic armed;
		logic slot_zero;
	} dec_status_t;

	typedef struct packed {
		logic main_valid;
		logic skid_valid;
	} buf_status_t;

endpackage

### hw/rtl/irpw_edge_if.sv
`timescale 1ns / 1ps

interface irpw_edge_if;
	logic       valid;
	logic       ready;
	logic [7:0] pulse_width;

	modport source (output valid, output pulse_width, input ready);
	modport sink (input valid, input pulse_width, output ready);
endinterface

### hw/rtl/irpw_frame_if.sv
`timescale 1ns / 1ps

interface irpw_frame_if;
	logic       valid;
	logic       ready;
	logic       frame_ready;
	logic [7:0] byte_zero;
	logic [7:0] byte_one;
	logic [7:0] byte_two;
	logic [7:0] byte_three;

	modport source (
		output valid, output frame_ready, output byte_zero, output byte_one,
		output byte_two, output byte_three, input ready
	);
	modport sink (
		input valid, input frame_ready, input byte_zero, input byte_one,
		input byte_two, input byte_three, output ready
	);
endinterface

### hw/rtl/irpw_slot_decoder.sv
`timescale 1ns / 1ps

module irpw_slot_decoder #(
	parameter int unsigned FRAME_SLOTS = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           pulse_width,
	input  irpw_pkg::cfg_t       cfg,
	output irpw_pkg::result_t    res,
	output irpw_pkg::dec_status_t status
);

	localparam int unsigned SLOT_W = $clog2(FRAME_SLOTS);

	logic                           armed_q;
	logic [SLOT_W-1:0]              slot_q;
	logic [irpw_pkg::DATA_BITS-1:0] bits_q;

	logic                           is_leader;
	logic                           is_one;
	logic [6:0]                     slot_eff;
	logic [6:0]                     slot_next;
	logic                           frame_done;
	logic [SLOT_W-1:0]              slot_d;
	logic [irpw_pkg::DATA_BITS-1:0] bits_d;

	always_comb begin
		is_leader  = (pulse_width >= cfg.leader_min) && (pulse_width <= cfg.leader_max);
		is_one     = pulse_width > cfg.one_threshold;
		slot_eff   = is_leader ? 7'd0 : 7'(slot_q);
		// slot 0 is the leader; slots past 32 carry no bit
		for (int k = 0; k < irpw_pkg::DATA_BITS; k++) begin
			bits_d[k] = (slot_eff == 7'(k + 1)) ? is_one : bits_q[k];
		end
		slot_next  = slot_eff + 7'd1;
		frame_done = slot_next >= 7'(FRAME_SLOTS);
		slot_d     = frame_done ? '0 : slot_next[SLOT_W-1:0];
	end

	always_comb begin
		res = '0;
		if (armed_q && frame_done) begin
			res.frame_ready = 1'b1;
			res.byte_zero   = bits_d[7:0];
			res.byte_one    = bits_d[15:8];
			res.byte_two    = bits_d[23:16];
			res.byte_three  = bits_d[31:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			slot_q  <= '0;
			bits_q  <= '0;
		end else if (fire) begin
			armed_q <= 1'b1;
			if (armed_q) begin
				slot_q <= slot_d;
				bits_q <= bits_d;
			end
		end
	end

	assign status.armed     = armed_q;
	assign status.slot_zero = (slot_q == '0);

endmodule

### hw/rtl/irpw_out_skid.sv
`timescale 1ns / 1ps

module irpw_out_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  irpw_pkg::result_t    din,
	output logic                 can_push,
	output irpw_pkg::buf_status_t status,
	irpw_frame_if.source         frames
);

	logic              main_valid_q;
	logic              skid_valid_q;
	irpw_pkg::result_t main_q;
	irpw_pkg::result_t skid_q;
	logic              pop;
	logic              main_free;

	assign pop       = main_valid_q && frames.ready;
	assign main_free = !main_valid_q || pop;
	assign can_push  = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : din;
		end
		if (!main_free && push) begin
			skid_q <= din;
		end
	end

	assign frames.valid       = main_valid_q;
	assign frames.frame_ready = main_q.frame_ready;
	assign frames.byte_zero   = main_q.byte_zero;
	assign frames.byte_one    = main_q.byte_one;
	assign frames.byte_two    = main_q.byte_two;
	assign frames.byte_three  = main_q.byte_three;

	assign status.main_valid = main_valid_q;
	assign status.skid_valid = skid_valid_q;

endmodule

### hw/rtl/ir_pulse_width_frame_decoder.sv
`timescale 1ns / 1ps
// Each edge transfer registers its result in the output buffer (result register or skid entry).
// One edge per cycle while the skid entry is free; slot compare and bit update are combinational.
// A two-entry output buffer keeps edges flowing while one result waits.
// Reset (arst_n low, asynchronous): decoder unarmed, slot 0, stored bits cleared,
// output buffer empty, registers back to leader 9..16 and threshold 7.

module ir_pulse_width_frame_decoder #(
	// number of slots in a frame, the leader slot included (9..64)
	parameter int unsigned FRAME_SLOTS = 33
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port, no read-back
	input  logic                                cfg_we,
	input  logic [irpw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                          cfg_wdata,
	// edge stream in, frame results out
	irpw_edge_if.sink                           edges,
	irpw_frame_if.source                        frames
);

	irpw_pkg::cfg_t        cfg_q;
	irpw_pkg::result_t     res;
	irpw_pkg::dec_status_t dec_status;
	irpw_pkg::buf_status_t buf_status;
	logic                  can_push;
	logic                  fire;

	// Configuration registers. Writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_min    <= irpw_pkg::LEADER_MIN_RST;
			cfg_q.leader_max    <= irpw_pkg::LEADER_MAX_RST;
			cfg_q.one_threshold <= irpw_pkg::ONE_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				irpw_pkg::REG_LEADER_MIN:    cfg_q.leader_min    <= cfg_wdata;
				irpw_pkg::REG_LEADER_MAX:    cfg_q.leader_max    <= cfg_wdata;
				irpw_pkg::REG_ONE_THRESHOLD: cfg_q.one_threshold <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// An edge transfers whenever the skid slot is free, so a stalled
	// result consumer costs one more edge of slack before we push back.
	assign edges.ready = can_push;
	assign fire        = edges.valid && can_push;

	// Slot counter, leader detect and bit store; result is combinational
	// from the incoming width and the current state.
	irpw_slot_decoder #(
		.FRAME_SLOTS (FRAME_SLOTS)
	) u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.pulse_width (edges.pulse_width),
		.cfg         (cfg_q),
		.res         (res),
		.status      (dec_status)
	);

	// Result register plus skid entry toward the frame consumer.
	irpw_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.din      (res),
		.can_push (can_push),
		.status   (buf_status),
		.frames   (frames)
	);

`ifndef SYNTHESIS
	// The arming edge never completes a frame.
	a_no_frame_unarmed: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !dec_status.armed) |-> !res.frame_ready)
		else $error("frame given on arming edge");

	// Any transfer leaves the decoder armed.
	a_armed_after_edge: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> dec_status.armed)
		else $error("decoder not armed after edge");

	// A completed frame restarts the slot count.
	a_slot_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.frame_ready) |=> dec_status.slot_zero)
		else $error("slot index not restarted after frame");

	// The skid entry only fills behind a held result.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		buf_status.skid_valid |-> buf_status.main_valid)
		else $error("skid entry valid with empty result register");
`endif

endmodule
